### rtl/nll_pkg.sv
// Shared types, constants and helper functions of the numeric literal lexer.
`timescale 1ns / 1ps

package nll_pkg;

  // Saturation point of the character count.
  localparam int unsigned MAX_TOKEN_LEN = 255;
  localparam int unsigned CNT_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned LEN_W = 8;
  localparam int unsigned KIND_W = 3;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_SIGN  = 3'd1,
    PH_ZERO  = 3'd2,
    PH_HEX   = 3'd3,
    PH_OCT   = 3'd4,
    PH_DEC   = 3'd5,
    PH_FLT   = 3'd6
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEX   = 3'd0,
    KIND_OCT   = 3'd1,
    KIND_DEC   = 3'd2,
    KIND_FLT   = 3'd3,
    KIND_EMPTY = 3'd4,
    KIND_BAD   = 3'd5
  } kind_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic is_zero;
    logic is_oct;
    logic is_dec;
    logic is_hex;
    logic is_x;
    logic is_dot;
    logic is_sign;
  } char_class_t;

  typedef struct packed {
    kind_t            kind;
    logic [LEN_W-1:0] length;
    logic             has_sign;
    logic             too_long;
  } token_res_t;

  // Saturating increment of the character count.
  function automatic cnt_t cnt_inc(input cnt_t c);
    if (32'(c) < MAX_TOKEN_LEN) begin
      return c + cnt_t'(1);
    end
    return c;
  endfunction

  function automatic token_res_t make_res(input kind_t k, input cnt_t len, input logic sgn);
    token_res_t r;
    r.kind     = k;
    r.length   = (32'(len) > 255) ? 8'hFF : LEN_W'(len);
    r.has_sign = sgn;
    r.too_long = (32'(len) >= MAX_TOKEN_LEN);
    return r;
  endfunction

endpackage

### rtl/nll_char_class.sv
// Character classifier: decodes one byte into the lexer's character classes.
`timescale 1ns / 1ps

module nll_char_class (
  input  logic [7:0]          ch,
  output nll_pkg::char_class_t cls
);

  logic dec_w;
  logic alpha_hex_w;

  assign dec_w = (ch >= nll_pkg::CH_ZERO) && (ch <= nll_pkg::CH_NINE);
  assign alpha_hex_w = ((ch >= nll_pkg::CH_UP_A) && (ch <= nll_pkg::CH_UP_F)) ||
                       ((ch >= nll_pkg::CH_LO_A) && (ch <= nll_pkg::CH_LO_F));

  always_comb begin
    cls.is_zero = (ch == nll_pkg::CH_ZERO);
    cls.is_oct  = (ch >= nll_pkg::CH_ZERO) && (ch <= nll_pkg::CH_SEVEN);
    cls.is_dec  = dec_w;
    cls.is_hex  = dec_w || alpha_hex_w;
    cls.is_x    = (ch == nll_pkg::CH_LO_X) || (ch == nll_pkg::CH_UP_X);
    cls.is_dot  = (ch == nll_pkg::CH_DOT);
    cls.is_sign = (ch == nll_pkg::CH_PLUS) || (ch == nll_pkg::CH_MINUS);
  end

endmodule

### rtl/nll_scan_fsm.sv
// Scanner state machine: phase, character count and sign flag, plus token results.
`timescale 1ns / 1ps

module nll_scan_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  nll_pkg::char_class_t cls,
  input  logic                 line_end,
  output logic                 res_valid,
  output nll_pkg::token_res_t  res
);

  nll_pkg::phase_t phase_r, phase_nxt;
  nll_pkg::cnt_t   cnt_r, cnt_nxt;
  logic            sign_r, sign_nxt;
  nll_pkg::cnt_t   cnt_plus;

  assign cnt_plus = nll_pkg::cnt_inc(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nll_pkg::PH_START;
      cnt_r   <= '0;
      sign_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sign_r  <= sign_nxt;
    end
  end

  // Next state. A token end clears everything back to the start of a token.
  always_comb begin
    phase_nxt = nll_pkg::PH_START;
    cnt_nxt   = '0;
    sign_nxt  = 1'b0;
    case (phase_r)
      nll_pkg::PH_START, nll_pkg::PH_SIGN: begin
        if (line_end) begin
          phase_nxt = nll_pkg::PH_START;
        end else if (cls.is_zero) begin
          phase_nxt = nll_pkg::PH_ZERO;
          cnt_nxt   = cnt_plus;
          sign_nxt  = sign_r;
        end else if (cls.is_dec) begin
          phase_nxt = nll_pkg::PH_DEC;
          cnt_nxt   = cnt_plus;
          sign_nxt  = sign_r;
        end else if ((phase_r == nll_pkg::PH_START) && cls.is_sign) begin
          phase_nxt = nll_pkg::PH_SIGN;
          cnt_nxt   = cnt_plus;
          sign_nxt  = 1'b1;
        end else if (phase_r == nll_pkg::PH_START) begin
          phase_nxt = nll_pkg::PH_START;
        end else begin
          // Skipped byte after a sign still counts toward the token.
          phase_nxt = nll_pkg::PH_SIGN;
          cnt_nxt   = cnt_plus;
          sign_nxt  = sign_r;
        end
      end
      nll_pkg::PH_ZERO: begin
        if (!line_end && (cls.is_x || cls.is_dot || cls.is_oct)) begin
          cnt_nxt  = cnt_plus;
          sign_nxt = sign_r;
          if (cls.is_x) begin
            phase_nxt = nll_pkg::PH_HEX;
          end else if (cls.is_dot) begin
            phase_nxt = nll_pkg::PH_FLT;
          end else begin
            phase_nxt = nll_pkg::PH_OCT;
          end
        end
      end
      nll_pkg::PH_HEX: begin
        if (!line_end && cls.is_hex) begin
          phase_nxt = nll_pkg::PH_HEX;
          cnt_nxt   = cnt_plus;
          sign_nxt  = sign_r;
        end
      end
      nll_pkg::PH_OCT: begin
        if (!line_end && cls.is_oct) begin
          phase_nxt = nll_pkg::PH_OCT;
          cnt_nxt   = cnt_plus;
          sign_nxt  = sign_r;
        end
      end
      nll_pkg::PH_DEC: begin
        if (!line_end && (cls.is_dec || cls.is_dot)) begin
          phase_nxt = cls.is_dec ? nll_pkg::PH_DEC : nll_pkg::PH_FLT;
          cnt_nxt   = cnt_plus;
          sign_nxt  = sign_r;
        end
      end
      nll_pkg::PH_FLT: begin
        if (!line_end && cls.is_dec) begin
          phase_nxt = nll_pkg::PH_FLT;
          cnt_nxt   = cnt_plus;
          sign_nxt  = sign_r;
        end
      end
      default: begin
        phase_nxt = nll_pkg::PH_START;
      end
    endcase
  end

  // Result of this character, if it ends or rejects a token.
  always_comb begin
    res_valid = 1'b0;
    res       = nll_pkg::make_res(nll_pkg::KIND_BAD, cnt_r, sign_r);
    case (phase_r)
      nll_pkg::PH_START, nll_pkg::PH_SIGN: begin
        if (line_end) begin
          res_valid = 1'b1;
          res       = nll_pkg::make_res(nll_pkg::KIND_EMPTY, cnt_r, sign_r);
        end else if (cls.is_dec || (phase_r == nll_pkg::PH_START && cls.is_sign)) begin
          res_valid = 1'b0;
        end else if (phase_r == nll_pkg::PH_START) begin
          res_valid = 1'b1;
          res       = nll_pkg::make_res(nll_pkg::KIND_BAD, nll_pkg::cnt_t'(1), 1'b0);
        end else begin
          res_valid = 1'b1;
          res       = nll_pkg::make_res(nll_pkg::KIND_BAD, cnt_plus, 1'b1);
        end
      end
      nll_pkg::PH_ZERO: begin
        res_valid = line_end || !(cls.is_x || cls.is_dot || cls.is_oct);
        res       = nll_pkg::make_res(nll_pkg::KIND_OCT, cnt_r, sign_r);
      end
      nll_pkg::PH_HEX: begin
        res_valid = line_end || !cls.is_hex;
        res       = nll_pkg::make_res(nll_pkg::KIND_HEX, cnt_r, sign_r);
      end
      nll_pkg::PH_OCT: begin
        res_valid = line_end || !cls.is_oct;
        res       = nll_pkg::make_res(nll_pkg::KIND_OCT, cnt_r, sign_r);
      end
      nll_pkg::PH_DEC: begin
        res_valid = line_end || !(cls.is_dec || cls.is_dot);
        res       = nll_pkg::make_res(nll_pkg::KIND_DEC, cnt_r, sign_r);
      end
      nll_pkg::PH_FLT: begin
        res_valid = line_end || !cls.is_dec;
        res       = nll_pkg::make_res(nll_pkg::KIND_FLT, cnt_r, sign_r);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

endmodule

### rtl/numeric_literal_lexer_top.sv
// Top level of the numeric literal lexer: input register, scanner and result register.
`timescale 1ns / 1ps

// Numeric literal lexer. Takes one character byte per request on the in_ stream
// (in_tlast marks line end, with in_tdata ignored) and returns one result per
// finished or rejected token on the out_ stream: out_tuser carries the token kind,
// out_tdata the length, sign flag and overlong flag. A request is registered in the
// input register, then classified and stepped through the scanner, whose result
// goes to the result register; the block sustains one character per clock while the
// result register is not stalled. The input register and the result register decouple
// the two sides, so only a stalled result register holds up the input.
module numeric_literal_lexer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] token_length, [8] has_sign, [9] too_long, zeros
  output logic [2:0]  out_tuser   // [2:0] token_kind
);

  logic                 in_valid_r;
  logic [7:0]           ch_r;
  logic                 end_r;
  logic                 step;
  logic                 res_valid;
  nll_pkg::token_res_t  res;
  nll_pkg::token_res_t  out_res_r;
  logic                 out_valid_r;
  nll_pkg::char_class_t cls;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r  <= in_tdata;
      end_r <= in_tlast;
    end
  end

  nll_char_class u_class (
    .ch  (ch_r),
    .cls (cls)
  );

  nll_scan_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cls       (cls),
    .line_end  (end_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {6'd0, out_res_r.too_long, out_res_r.has_sign, out_res_r.length};

endmodule

### tb/tb_numeric_literal_lexer_top.sv
// Self-checking testbench for the numeric literal lexer with random stream stalls.
`timescale 1ns / 1ps

module tb_numeric_literal_lexer_top;
  import nll_pkg::*;

  localparam int QUIET_TAIL     = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_CHARS   = 2000;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } char_req_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  char_req_t  char_queue[$];
  token_res_t token_queue[$];

  // Scanner state of the predictor.
  phase_t      lex_phase  = PH_START;
  int unsigned tok_count  = 0;
  logic        tok_signed = 1'b0;

  logic in_taken     = 1'b0;
  int   send_gap     = 0;
  int   take_gap     = 0;
  int   quiet_cycles = 0;
  int   fail_count   = 0;

  numeric_literal_lexer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic token_res_t token_fields(input kind_t k, input int unsigned n,
                                              input logic s);
    token_res_t r;
    r.kind     = k;
    r.length   = (n > 255) ? 8'hFF : 8'(n);
    r.has_sign = s;
    r.too_long = (n >= MAX_TOKEN_LEN);
    return r;
  endfunction

  function automatic void bump();
    if (tok_count < MAX_TOKEN_LEN) begin
      tok_count++;
    end
  endfunction

  function automatic token_res_t close_token(input kind_t k);
    token_res_t r;
    r = token_fields(k, tok_count, tok_signed);
    lex_phase  = PH_START;
    tok_count  = 0;
    tok_signed = 1'b0;
    return r;
  endfunction

  // Advances the scanner by one character; returns 1 when a token is reported.
  function automatic bit lex_char(input logic [7:0] c, input logic at_end,
                                  output token_res_t res);
    bit oct_d, dec_d, hex_d, got;
    oct_d = (c >= CH_ZERO) && (c <= CH_SEVEN);
    dec_d = (c >= CH_ZERO) && (c <= CH_NINE);
    hex_d = dec_d || ((c >= CH_UP_A) && (c <= CH_UP_F)) || ((c >= CH_LO_A) && (c <= CH_LO_F));
    res = '0;
    got = 1'b0;
    case (lex_phase)
      PH_START, PH_SIGN: begin
        if (at_end) begin
          res = close_token(KIND_EMPTY);
          got = 1'b1;
        end else if (c == CH_ZERO) begin
          bump();
          lex_phase = PH_ZERO;
        end else if (dec_d) begin
          bump();
          lex_phase = PH_DEC;
        end else if (lex_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
          bump();
          tok_signed = 1'b1;
          lex_phase = PH_SIGN;
        end else if (lex_phase == PH_START) begin
          res = token_fields(KIND_BAD, 1, 1'b0);
          got = 1'b1;
        end else begin
          // The rejected byte still counts toward the signed token.
          bump();
          res = token_fields(KIND_BAD, tok_count, 1'b1);
          got = 1'b1;
        end
      end
      PH_ZERO: begin
        if (!at_end && (c == CH_LO_X || c == CH_UP_X)) begin
          bump();
          lex_phase = PH_HEX;
        end else if (!at_end && c == CH_DOT) begin
          bump();
          lex_phase = PH_FLT;
        end else if (!at_end && oct_d) begin
          bump();
          lex_phase = PH_OCT;
        end else begin
          res = close_token(KIND_OCT);
          got = 1'b1;
        end
      end
      PH_HEX: begin
        if (!at_end && hex_d) begin
          bump();
        end else begin
          res = close_token(KIND_HEX);
          got = 1'b1;
        end
      end
      PH_OCT: begin
        if (!at_end && oct_d) begin
          bump();
        end else begin
          res = close_token(KIND_OCT);
          got = 1'b1;
        end
      end
      PH_DEC: begin
        if (!at_end && dec_d) begin
          bump();
        end else if (!at_end && c == CH_DOT) begin
          bump();
          lex_phase = PH_FLT;
        end else begin
          res = close_token(KIND_DEC);
          got = 1'b1;
        end
      end
      PH_FLT: begin
        if (!at_end && dec_d) begin
          bump();
        end else begin
          res = close_token(KIND_FLT);
          got = 1'b1;
        end
      end
      default: begin
        lex_phase  = PH_START;
        tok_count  = 0;
        tok_signed = 1'b0;
      end
    endcase
    return got;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic at_end);
    char_queue.push_back('{c, at_end});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], 1'b0);
    end
  endtask

  task automatic push_eol();
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic push_sign();
    push_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
  endtask

  // A well-formed literal of random form and content, then a space, comma, line end or random byte.
  task automatic add_literal();
    string hexset;
    int    ndig;
    hexset = "0123456789abcdefABCDEF";
    ndig = $urandom_range(0, 6);
    if ($urandom_range(0, 2) == 0) begin
      push_sign();
    end
    case ($urandom_range(0, 3))
      0: begin
        push_char(CH_ZERO, 1'b0);
        push_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X, 1'b0);
        repeat (ndig) push_char(hexset[$urandom_range(0, 21)], 1'b0);
      end
      1: begin
        push_char(CH_ZERO, 1'b0);
        repeat (ndig) push_char(8'(CH_ZERO + $urandom_range(0, 7)), 1'b0);
      end
      2: begin
        push_char(8'(CH_ZERO + $urandom_range(1, 9)), 1'b0);
        repeat (ndig) push_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
      end
      default: begin
        push_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        repeat ($urandom_range(0, 3)) push_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        push_char(CH_DOT, 1'b0);
        repeat (ndig) push_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
      end
    endcase
    case ($urandom_range(0, 3))
      0: push_eol();
      1: push_text(" ");
      2: push_char(8'($urandom_range(0, 255)), 1'b0);
      default: push_text(",");
    endcase
  endtask

  task automatic add_noise();
    string confusers;
    confusers = "+-.xX089 ";
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1)) begin
        push_char(8'($urandom_range(0, 255)), 1'b0);
      end else if ($urandom_range(0, 5) == 0) begin
        push_eol();
      end else begin
        push_char(confusers[$urandom_range(0, confusers.len() - 1)], 1'b0);
      end
    end
  endtask

  task automatic add_long(input int n);
    if ($urandom_range(0, 1)) begin
      push_sign();
    end
    push_char(8'(CH_ZERO + $urandom_range(1, 9)), 1'b0);
    repeat (n - 1) push_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    push_eol();
  endtask

  // Driver: holds a request until it is taken, then moves on or idles.
  always @(negedge clk) begin : drive
    char_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // Request still pending.
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (char_queue.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
      in_tvalid <= 1'b0;
      send_gap  <= $urandom_range(0, 7);
    end else if (char_queue.size() != 0) begin
      req = char_queue.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= req.ch;
      in_tlast  <= req.at_end;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (take_gap > 0) begin
      out_tready <= 1'b0;
      take_gap   <= take_gap - 1;
    end else if (rst_n && char_queue.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      take_gap   <= $urandom_range(0, 7);
    end else begin
      out_tready <= rst_n;
    end
  end

  // Monitor: predicts on every accepted character and checks every result.
  always @(posedge clk) begin : observe
    token_res_t want;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      if (lex_char(in_tdata, in_tlast, want)) begin
        token_queue.push_back(want);
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (token_queue.size() == 0) begin
        $error("token reported with none expected: kind %0d, out_tdata %h",
               out_tuser, out_tdata);
        fail_count++;
      end else begin
        want = token_queue.pop_front();
        if (out_tuser !== want.kind) begin
          $error("token_kind mismatch: expected %0d, got %0d", want.kind, out_tuser);
          fail_count++;
        end
        if (out_tdata[7:0] !== want.length) begin
          $error("token_length mismatch: expected %0d, got %0d", want.length, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[8] !== want.has_sign) begin
          $error("has_sign mismatch: expected %0b, got %0b", want.has_sign, out_tdata[8]);
          fail_count++;
        end
        if (out_tdata[9] !== want.too_long) begin
          $error("too_long mismatch: expected %0b, got %0b", want.too_long, out_tdata[9]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // Directed: line ends, rejected bytes with and without a sign, and every form.
    push_eol();
    push_text(".");
    push_char(8'hFF, 1'b0);
    push_text("+q-");
    push_eol();
    push_text("08");
    push_text("0xg");
    push_text("-0Xf");
    push_eol();
    push_text("07.");
    push_text("1.5");
    push_char(8'h80, 1'b0);
    push_text("9");
    push_eol();

    // Counts around the saturation point, including a long run of rejected bytes.
    add_long(254);
    add_long(255);
    add_long(256);
    add_long($urandom_range(257, 300));
    push_text("+");
    repeat (260) push_text("z");
    push_eol();

    while (char_queue.size() < RANDOM_CHARS) begin
      if ($urandom_range(0, 99) < 85) begin
        add_literal();
      end else begin
        add_noise();
      end
    end
    push_eol();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (char_queue.size() != 0 || in_tvalid || token_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
